### sv/cpra_pkg.sv
// ----------------------------------------------------------------------------
// cpra_pkg
// shared types and constants of the contiguous page run allocator
// ----------------------------------------------------------------------------
`default_nettype none

package cpra_pkg;

  localparam int MAP_PAGES = 128;
  localparam int CMD_W     = 2;
  localparam int REQ_W     = 29;
  localparam int HND_W     = 7;
  localparam int ST_W      = 2;
  localparam int FP_W      = 7;
  localparam int PC_W      = 8;
  localparam int IDX_W     = 11;
  localparam int NEED_W    = 31;
  localparam int OP_W      = 4;

  localparam logic [CMD_W-1:0] CMD_FORM  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD   = 2'd2;
  localparam logic [ST_W-1:0] ST_ZERO  = 2'd3;

  localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD      = 4'd1;
  localparam logic [OP_W-1:0] OP_CAP       = 4'd2;
  localparam logic [OP_W-1:0] OP_FORM_STEP = 4'd3;
  localparam logic [OP_W-1:0] OP_FORM_END  = 4'd4;
  localparam logic [OP_W-1:0] OP_SCAN      = 4'd5;
  localparam logic [OP_W-1:0] OP_TAKE      = 4'd6;
  localparam logic [OP_W-1:0] OP_SPLIT_A   = 4'd7;
  localparam logic [OP_W-1:0] OP_SPLIT_B   = 4'd8;
  localparam logic [OP_W-1:0] OP_LEFT      = 4'd9;
  localparam logic [OP_W-1:0] OP_MERGE_L   = 4'd10;
  localparam logic [OP_W-1:0] OP_RIGHT     = 4'd11;
  localparam logic [OP_W-1:0] OP_MERGE_R   = 4'd12;
  localparam logic [OP_W-1:0] OP_FREE_DONE = 4'd13;
  localparam logic [OP_W-1:0] OP_REJECT    = 4'd14;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [ST_W-1:0] code;
  } dp_cmd_t;

  typedef struct packed {
    logic formed;
    logic zero_req;
    logic handle_ok;
    logic h_follows;
    logic form_last;
    logic scan_last;
    logic found;
    logic rest_zero;
    logic left_stop;
    logic left_free;
    logic right_ok;
  } dp_stat_t;

  // page p follows p-1 in the contiguity map
  function automatic logic follows_f(input logic [IDX_W-1:0] p,
                                     input logic [2*64-1:0] m);
    return (p != '0) && (p < IDX_W'(MAP_PAGES)) && m[p[6:0]];
  endfunction

endpackage

`default_nettype wire

### sv/cpra_regs.sv
// ----------------------------------------------------------------------------
// cpra_regs
// apb register file holding the two halves of the contiguity map
// ----------------------------------------------------------------------------
`default_nettype none

module cpra_regs (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic      [63:0]  prdata,
  output logic              pready,
  output logic      [127:0] follows_map
);

  logic [63:0] map_low_r;
  logic [63:0] map_high_r;
  logic        wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_low_r  <= '0;
      map_high_r <= '0;
    end else if (wr_en) begin
      if (paddr[3]) begin
        map_high_r <= pwdata;
      end else begin
        map_low_r <= pwdata;
      end
    end
  end

  assign prdata      = paddr[3] ? map_high_r : map_low_r;
  assign follows_map = {map_high_r, map_low_r};

endmodule

`default_nettype wire

### sv/cpra_ctrl.sv
// ----------------------------------------------------------------------------
// cpra_ctrl
// sequencer that steps the datapath through form, allocate and free
// ----------------------------------------------------------------------------
`default_nettype none

module cpra_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [cpra_pkg::CMD_W-1:0]  in_cmd,
  input  wire cpra_pkg::dp_stat_t          stat,
  output cpra_pkg::dp_cmd_t                cmd,
  output logic                             busy
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DISP      = 4'd1;
  localparam logic [3:0] S_FORM      = 4'd2;
  localparam logic [3:0] S_FORM_END  = 4'd3;
  localparam logic [3:0] S_SCAN      = 4'd4;
  localparam logic [3:0] S_ALLOC_DEC = 4'd5;
  localparam logic [3:0] S_SPLIT_B   = 4'd6;
  localparam logic [3:0] S_LEFT      = 4'd7;
  localparam logic [3:0] S_MERGE_L   = 4'd8;
  localparam logic [3:0] S_RIGHT     = 4'd9;
  localparam logic [3:0] S_MERGE_R   = 4'd10;
  localparam logic [3:0] S_FREE_DONE = 4'd11;
  localparam logic [3:0] S_REJECT    = 4'd12;

  logic [3:0]                     state_r, state_nxt;
  logic [cpra_pkg::CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [cpra_pkg::ST_W-1:0]      code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cmd_r   <= cpra_pkg::CMD_FORM;
      code_r  <= cpra_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
      code_r  <= code_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    code_nxt  = code_r;
    cmd.op    = cpra_pkg::OP_NONE;
    cmd.code  = code_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = cpra_pkg::OP_LOAD;
          cmd_nxt   = in_cmd;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmd.op = cpra_pkg::OP_CAP;
        unique case (cmd_r)
          cpra_pkg::CMD_FORM: state_nxt = S_FORM;
          cpra_pkg::CMD_ALLOC: begin
            if (!stat.formed) begin
              code_nxt  = cpra_pkg::ST_BAD;
              state_nxt = S_REJECT;
            end else if (stat.zero_req) begin
              code_nxt  = cpra_pkg::ST_ZERO;
              state_nxt = S_REJECT;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          cpra_pkg::CMD_FREE: begin
            if (!stat.formed || !stat.handle_ok) begin
              code_nxt  = cpra_pkg::ST_BAD;
              state_nxt = S_REJECT;
            end else if (stat.h_follows) begin
              state_nxt = S_LEFT;
            end else begin
              state_nxt = S_RIGHT;
            end
          end
          default: begin
            code_nxt  = cpra_pkg::ST_BAD;
            state_nxt = S_REJECT;
          end
        endcase
      end
      S_FORM: begin
        cmd.op = cpra_pkg::OP_FORM_STEP;
        if (stat.form_last) begin
          state_nxt = S_FORM_END;
        end
      end
      S_FORM_END: begin
        cmd.op    = cpra_pkg::OP_FORM_END;
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        cmd.op = cpra_pkg::OP_SCAN;
        if (stat.scan_last) begin
          state_nxt = S_ALLOC_DEC;
        end
      end
      S_ALLOC_DEC: begin
        if (!stat.found) begin
          cmd.op    = cpra_pkg::OP_REJECT;
          cmd.code  = cpra_pkg::ST_NOFIT;
          state_nxt = S_IDLE;
        end else if (stat.rest_zero) begin
          cmd.op    = cpra_pkg::OP_TAKE;
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = cpra_pkg::OP_SPLIT_A;
          state_nxt = S_SPLIT_B;
        end
      end
      S_SPLIT_B: begin
        cmd.op    = cpra_pkg::OP_SPLIT_B;
        state_nxt = S_IDLE;
      end
      S_LEFT: begin
        cmd.op = cpra_pkg::OP_LEFT;
        if (stat.left_stop) begin
          state_nxt = stat.left_free ? S_MERGE_L : S_RIGHT;
        end
      end
      S_MERGE_L: begin
        cmd.op    = cpra_pkg::OP_MERGE_L;
        state_nxt = S_RIGHT;
      end
      S_RIGHT: begin
        cmd.op    = cpra_pkg::OP_RIGHT;
        state_nxt = stat.right_ok ? S_MERGE_R : S_FREE_DONE;
      end
      S_MERGE_R: begin
        cmd.op    = cpra_pkg::OP_MERGE_R;
        state_nxt = S_FREE_DONE;
      end
      S_FREE_DONE: begin
        cmd.op    = cpra_pkg::OP_FREE_DONE;
        state_nxt = S_IDLE;
      end
      S_REJECT: begin
        cmd.op    = cpra_pkg::OP_REJECT;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### sv/cpra_dp.sv
// ----------------------------------------------------------------------------
// cpra_dp
// run tables, run length memory, scan counters and result register
// ----------------------------------------------------------------------------
`default_nettype none

module cpra_dp #(
  parameter int PAGES           = 128,
  parameter int PAGE_BYTES_LOG2 = 21
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [cpra_pkg::REQ_W-1:0]  in_request_bytes,
  input  wire logic [cpra_pkg::HND_W-1:0]  in_run_handle,
  input  wire logic [127:0]                follows_map,
  input  wire cpra_pkg::dp_cmd_t           cmd,
  output cpra_pkg::dp_stat_t               stat,
  output logic                             out_valid,
  output logic [cpra_pkg::ST_W-1:0]        out_status,
  output logic [cpra_pkg::FP_W-1:0]        out_first_page,
  output logic [cpra_pkg::PC_W-1:0]        out_page_count
);

  localparam int PW     = $clog2(PAGES);
  localparam int LW     = $clog2(PAGES + 1);
  localparam int IW     = cpra_pkg::IDX_W;
  localparam int NW     = cpra_pkg::NEED_W;
  localparam logic [NW-1:0] MASK = NW'((64'd1 << PAGE_BYTES_LOG2) - 64'd1);

  logic [LW-1:0] len_mem [PAGES];
  logic [LW-1:0] rd_data_r;
  logic [PW-1:0] rd_addr;
  logic          we;
  logic [PW-1:0] wa;
  logic [LW-1:0] wd;

  logic [PAGES-1:0] mark_r;
  logic [PAGES-1:0] free_r;
  logic             formed_r;

  logic [NW-1:0]          need_r;
  logic                   zero_r;
  logic [cpra_pkg::HND_W-1:0] h_r;
  logic [PW:0]            cnt_r;
  logic                   pv_r;
  logic [PW-1:0]          pd_r;
  logic                   found_r;
  logic [PW-1:0]          best_r;
  logic [LW-1:0]          blen_r;
  logic [PW-1:0]          fstart_r;
  logic [LW-1:0]          flen_r;
  logic [PW-1:0]          left_r;
  logic [PW-1:0]          pg_r;
  logic [LW-1:0]          cur_r;

  logic                         valid_r;
  logic [cpra_pkg::ST_W-1:0]    status_r;
  logic [cpra_pkg::FP_W-1:0]    first_r;
  logic [cpra_pkg::PC_W-1:0]    count_r;

  logic [IW-1:0] hx;
  logic [PW-1:0] hi;
  logic [IW-1:0] cnt_x;
  logic [PW-1:0] cnt_i;
  logic          cnt_fol;
  logic          scan_hit;
  logic [LW-1:0] rest;
  logic [PW-1:0] split_pg;
  logic [PW:0]   right;
  logic [PW-1:0] ri;
  logic [LW-1:0] sum;
  logic [IW-1:0] res_pg_x;
  logic [IW-1:0] res_cnt_x;
  logic [NW-1:0] need_nxt;

  assign hx      = IW'(h_r);
  assign hi      = hx[PW-1:0];
  assign cnt_x   = IW'(cnt_r);
  assign cnt_i   = cnt_r[PW-1:0];
  assign cnt_fol = cpra_pkg::follows_f(cnt_x, follows_map);
  assign rest    = blen_r - need_r[LW-1:0];
  assign split_pg = best_r + rest[PW-1:0];
  assign right   = {1'b0, pg_r} + (PW+1)'(cur_r);
  assign ri      = right[PW-1:0];
  assign sum     = cur_r + rd_data_r;
  assign need_nxt = (NW'(in_request_bytes) + MASK) >> PAGE_BYTES_LOG2;

  assign scan_hit = pv_r && mark_r[pd_r] && free_r[pd_r] &&
                    (NW'(rd_data_r) >= need_r) &&
                    (!found_r || (rd_data_r < blen_r));

  always_comb begin
    stat.formed    = formed_r;
    stat.zero_req  = zero_r;
    stat.handle_ok = (hx < IW'(PAGES)) && mark_r[hi] && !free_r[hi];
    stat.h_follows = cpra_pkg::follows_f(hx, follows_map);
    stat.form_last = (cnt_r == (PW+1)'(PAGES - 1));
    stat.scan_last = (cnt_r == (PW+1)'(PAGES));
    stat.found     = found_r;
    stat.rest_zero = (rest == '0);
    stat.left_stop = (left_r == '0) || mark_r[left_r];
    stat.left_free = mark_r[left_r] && free_r[left_r];
    stat.right_ok  = (right < (PW+1)'(PAGES)) &&
                     cpra_pkg::follows_f(IW'(right), follows_map) &&
                     mark_r[ri] && free_r[ri];
  end

  // memory port selection
  always_comb begin
    rd_addr = cnt_i;
    we      = 1'b0;
    wa      = fstart_r;
    wd      = flen_r;
    case (cmd.op)
      cpra_pkg::OP_LOAD:  rd_addr = PW'(IW'(in_run_handle));
      cpra_pkg::OP_LEFT:  rd_addr = left_r;
      cpra_pkg::OP_RIGHT: rd_addr = ri;
      cpra_pkg::OP_FORM_STEP: begin
        if ((cnt_r != '0) && !cnt_fol) begin
          we = 1'b1;
        end
      end
      cpra_pkg::OP_FORM_END: we = 1'b1;
      cpra_pkg::OP_SPLIT_A: begin
        we = 1'b1;
        wa = best_r;
        wd = rest;
      end
      cpra_pkg::OP_SPLIT_B: begin
        we = 1'b1;
        wa = split_pg;
        wd = need_r[LW-1:0];
      end
      cpra_pkg::OP_MERGE_L: begin
        we = 1'b1;
        wa = left_r;
        wd = sum;
      end
      cpra_pkg::OP_MERGE_R: begin
        we = 1'b1;
        wa = pg_r;
        wd = sum;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      len_mem[wa] <= wd;
    end
    rd_data_r <= len_mem[rd_addr];
  end

  // run tables and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r   <= '0;
      free_r   <= '0;
      formed_r <= 1'b0;
      valid_r  <= 1'b0;
      cnt_r    <= '0;
      pv_r     <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      valid_r <= 1'b0;
      case (cmd.op)
        cpra_pkg::OP_LOAD: begin
          cnt_r   <= '0;
          pv_r    <= 1'b0;
          found_r <= 1'b0;
        end
        cpra_pkg::OP_FORM_STEP: begin
          cnt_r <= cnt_r + 1'b1;
          if ((cnt_r == '0) || !cnt_fol) begin
            mark_r[cnt_i] <= 1'b1;
            free_r[cnt_i] <= 1'b1;
          end else begin
            mark_r[cnt_i] <= 1'b0;
            free_r[cnt_i] <= 1'b0;
          end
        end
        cpra_pkg::OP_FORM_END: begin
          formed_r <= 1'b1;
          valid_r  <= 1'b1;
        end
        cpra_pkg::OP_SCAN: begin
          pv_r <= (cnt_r < (PW+1)'(PAGES));
          if (cnt_r < (PW+1)'(PAGES)) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (scan_hit) begin
            found_r <= 1'b1;
          end
        end
        cpra_pkg::OP_TAKE: begin
          free_r[best_r] <= 1'b0;
          valid_r        <= 1'b1;
        end
        cpra_pkg::OP_SPLIT_B: begin
          mark_r[split_pg] <= 1'b1;
          free_r[split_pg] <= 1'b0;
          valid_r          <= 1'b1;
        end
        cpra_pkg::OP_MERGE_L: begin
          mark_r[pg_r] <= 1'b0;
          free_r[pg_r] <= 1'b0;
        end
        cpra_pkg::OP_MERGE_R: begin
          mark_r[ri] <= 1'b0;
          free_r[ri] <= 1'b0;
        end
        cpra_pkg::OP_FREE_DONE: begin
          free_r[pg_r] <= 1'b1;
          valid_r      <= 1'b1;
        end
        cpra_pkg::OP_REJECT: valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      cpra_pkg::OP_LOAD: begin
        need_r <= need_nxt;
        zero_r <= (in_request_bytes == '0);
        h_r    <= in_run_handle;
      end
      cpra_pkg::OP_CAP: begin
        cur_r  <= rd_data_r;
        pg_r   <= hi;
        left_r <= hi - 1'b1;
      end
      cpra_pkg::OP_FORM_STEP: begin
        if (cnt_r == '0) begin
          fstart_r <= '0;
          flen_r   <= LW'(1);
        end else if (cnt_fol) begin
          flen_r <= flen_r + 1'b1;
        end else begin
          fstart_r <= cnt_i;
          flen_r   <= LW'(1);
        end
      end
      cpra_pkg::OP_SCAN: begin
        pd_r <= cnt_i;
        if (scan_hit) begin
          best_r <= pd_r;
          blen_r <= rd_data_r;
        end
      end
      cpra_pkg::OP_LEFT: begin
        if (!stat.left_stop) begin
          left_r <= left_r - 1'b1;
        end
      end
      cpra_pkg::OP_MERGE_L: begin
        cur_r <= sum;
        pg_r  <= left_r;
      end
      cpra_pkg::OP_MERGE_R: cur_r <= sum;
      default: ;
    endcase
  end

  // result register
  always_comb begin
    res_pg_x  = '0;
    res_cnt_x = '0;
    case (cmd.op)
      cpra_pkg::OP_TAKE: begin
        res_pg_x  = IW'(best_r);
        res_cnt_x = IW'(blen_r);
      end
      cpra_pkg::OP_SPLIT_B: begin
        res_pg_x  = IW'(split_pg);
        res_cnt_x = IW'(need_r[LW-1:0]);
      end
      cpra_pkg::OP_FREE_DONE: begin
        res_pg_x  = IW'(pg_r);
        res_cnt_x = IW'(cur_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == cpra_pkg::OP_REJECT) begin
      status_r <= cmd.code;
    end else begin
      status_r <= cpra_pkg::ST_OK;
    end
    first_r <= res_pg_x[cpra_pkg::FP_W-1:0];
    count_r <= res_cnt_x[cpra_pkg::PC_W-1:0];
  end

  assign out_valid      = valid_r;
  assign out_status     = status_r;
  assign out_first_page = first_r;
  assign out_page_count = count_r;

endmodule

`default_nettype wire

### sv/contiguous_page_run_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_page_run_allocator
// best fit allocator of contiguous huge page runs with coalescing on free
// ----------------------------------------------------------------------------
// an item is taken when start is high and busy is low; in_cmd selects form
// (0), allocate (1) or free (2). exactly one result follows per item, shown
// for one cycle with out_valid high; it cannot be held off.
// the contiguity map sits in two 64-bit apb registers at 0x0 and 0x8; write
// them only while busy is low.
// form steps through every page; allocate scans the whole run length memory,
// walked one entry per cycle by the scan counter, then takes or splits the
// best run; free walks down page by page to the left neighbour run start when
// the run follows it, then merges with free neighbours. busy falls in the
// result cycle, so the next item may be taken there.
// after reset no runs exist and the map is zero: allocate and free answer
// bad handle until a form item has been run.
// ----------------------------------------------------------------------------
`default_nettype none

module contiguous_page_run_allocator #(
  parameter int PAGES           = 128,
  parameter int PAGE_BYTES_LOG2 = 21
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [cpra_pkg::CMD_W-1:0]  in_cmd,
  input  wire logic [cpra_pkg::REQ_W-1:0]  in_request_bytes,
  input  wire logic [cpra_pkg::HND_W-1:0]  in_run_handle,
  output logic                             out_valid,
  output logic [cpra_pkg::ST_W-1:0]        out_status,
  output logic [cpra_pkg::FP_W-1:0]        out_first_page,
  output logic [cpra_pkg::PC_W-1:0]        out_page_count,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [3:0]                  paddr,
  input  wire logic [63:0]                 pwdata,
  output logic      [63:0]                 prdata,
  output logic                             pready
);

  logic [127:0]       follows_map;
  cpra_pkg::dp_cmd_t  cmd;
  cpra_pkg::dp_stat_t stat;

  cpra_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .follows_map (follows_map)
  );

  cpra_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  cpra_dp #(
    .PAGES           (PAGES),
    .PAGE_BYTES_LOG2 (PAGE_BYTES_LOG2)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_request_bytes (in_request_bytes),
    .in_run_handle    (in_run_handle),
    .follows_map      (follows_map),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_first_page   (out_first_page),
    .out_page_count   (out_page_count)
  );

endmodule

`default_nettype wire

### sv/cpra_checker.sv
// ----------------------------------------------------------------------------
// cpra_checker
// port level checks of the allocator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module cpra_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic [1:0] out_status,
  input wire logic [6:0] out_first_page,
  input wire logic [7:0] out_page_count,
  input wire logic       pready
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("item taken but busy not raised");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  a_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != cpra_pkg::ST_OK) |->
      (out_first_page == 7'd0) && (out_page_count == 8'd0))
    else $error("failed result carries a run");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind contiguous_page_run_allocator cpra_checker u_cpra_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_first_page (out_first_page),
  .out_page_count (out_page_count),
  .pready         (pready)
);

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the contiguous page run allocator
// ----------------------------------------------------------------------------
// a queue of pending items feeds a clocked driver; a clocked monitor compares
// every result with the expectation computed when its item was accepted. the
// page map is rewritten between phases, and each phase changes how often the
// sender idles. most random items are small allocations and frees of live
// runs, with some noise mixed in.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int PAGE_BYTES_LOG2_TB = 21;
  localparam logic [cpra_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [cpra_pkg::CMD_W-1:0] cmd;
    logic [cpra_pkg::REQ_W-1:0] bytes;
    logic [cpra_pkg::HND_W-1:0] handle;
    bit                         live;
  } item_t;

  typedef struct {
    logic [cpra_pkg::ST_W-1:0] status;
    logic [cpra_pkg::FP_W-1:0] first_page;
    logic [cpra_pkg::PC_W-1:0] page_count;
  } run_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [cpra_pkg::CMD_W-1:0] in_cmd = '0;
  logic [cpra_pkg::REQ_W-1:0] in_request_bytes = '0;
  logic [cpra_pkg::HND_W-1:0] in_run_handle = '0;
  logic out_valid;
  logic [cpra_pkg::ST_W-1:0] out_status;
  logic [cpra_pkg::FP_W-1:0] out_first_page;
  logic [cpra_pkg::PC_W-1:0] out_page_count;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  contiguous_page_run_allocator DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_request_bytes(in_request_bytes),
    .in_run_handle(in_run_handle), .out_valid(out_valid),
    .out_status(out_status), .out_first_page(out_first_page),
    .out_page_count(out_page_count), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #1 clk = ~clk;

  // allocator mirror
  logic [127:0] page_map = '0;
  bit           run_head [cpra_pkg::MAP_PAGES];
  logic [7:0]   run_len  [cpra_pkg::MAP_PAGES];
  bit           run_free [cpra_pkg::MAP_PAGES];
  bit           runs_formed = 1'b0;

  item_t    pending_q[$];
  run_res_t awaited_q[$];
  item_t    cur_item;
  int       gap_pct = 0;
  int       fail_cnt = 0;
  int       seen_cnt = 0;
  int       alloc_ok_cnt = 0;

  function automatic bit page_linked(int p);
    return (p != 0) && (p < cpra_pkg::MAP_PAGES) && page_map[p];
  endfunction

  function automatic run_res_t apply_item(item_t it);
    run_res_t r;
    logic [30:0] need;
    int best, best_len, rest, h, lft, rgt;
    bit found;
    r = '{cpra_pkg::ST_BAD, '0, '0};
    found = 1'b0;
    best = 0;
    best_len = 0;
    if (it.cmd == cpra_pkg::CMD_FORM) begin
      for (int p = 0; p < cpra_pkg::MAP_PAGES; p++) begin
        run_head[p] = 1'b0;
        run_free[p] = 1'b0;
      end
      best = 0;
      run_head[0] = 1'b1;
      run_free[0] = 1'b1;
      run_len[0] = 8'd1;
      for (int p = 1; p < cpra_pkg::MAP_PAGES; p++) begin
        if (page_linked(p)) begin
          run_len[best] = run_len[best] + 8'd1;
        end else begin
          best = p;
          run_head[p] = 1'b1;
          run_free[p] = 1'b1;
          run_len[p] = 8'd1;
        end
      end
      runs_formed = 1'b1;
      r = '{cpra_pkg::ST_OK, '0, '0};
    end else if (it.cmd == cpra_pkg::CMD_ALLOC && runs_formed) begin
      if (it.bytes == '0) begin
        r = '{cpra_pkg::ST_ZERO, '0, '0};
      end else begin
        need = ({2'b0, it.bytes} + 31'h1FFFFF) >> PAGE_BYTES_LOG2_TB;
        for (int p = 0; p < cpra_pkg::MAP_PAGES; p++) begin
          if (run_head[p] && run_free[p] && run_len[p] >= need &&
              (!found || run_len[p] < best_len)) begin
            found = 1'b1;
            best = p;
            best_len = run_len[p];
          end
        end
        if (!found) begin
          r = '{cpra_pkg::ST_NOFIT, '0, '0};
        end else begin
          rest = best_len - int'(need);
          if (rest == 0) begin
            run_free[best] = 1'b0;
            r = '{cpra_pkg::ST_OK, best[6:0], best_len[7:0]};
          end else begin
            run_len[best] = rest[7:0];
            h = best + rest;
            run_head[h] = 1'b1;
            run_free[h] = 1'b0;
            run_len[h] = need[7:0];
            r = '{cpra_pkg::ST_OK, h[6:0], need[7:0]};
          end
        end
      end
    end else if (it.cmd == cpra_pkg::CMD_FREE && runs_formed) begin
      h = it.handle;
      if (run_head[h] && !run_free[h]) begin
        if (h != 0 && page_linked(h)) begin
          lft = h - 1;
          while (lft > 0 && !run_head[lft]) lft--;
          if (run_head[lft] && run_free[lft]) begin
            run_len[lft] = run_len[lft] + run_len[h];
            run_head[h] = 1'b0;
            run_free[h] = 1'b0;
            h = lft;
          end
        end
        rgt = h + run_len[h];
        if (rgt < cpra_pkg::MAP_PAGES && page_linked(rgt) && run_head[rgt] &&
            run_free[rgt]) begin
          run_len[h] = run_len[h] + run_len[rgt];
          run_head[rgt] = 1'b0;
          run_free[rgt] = 1'b0;
        end
        run_free[h] = 1'b1;
        r = '{cpra_pkg::ST_OK, h[6:0], run_len[h]};
      end
    end
    return r;
  endfunction

  // driver
  item_t nxt;
  int    live_heads[$];
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) awaited_q.push_back(apply_item(cur_item));
      if (!start || !busy) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= gap_pct) begin
          nxt = pending_q.pop_front();
          if (nxt.live) begin
            live_heads.delete();
            for (int p = 0; p < cpra_pkg::MAP_PAGES; p++)
              if (runs_formed && run_head[p] && !run_free[p]) live_heads.push_back(p);
            if (live_heads.size() > 0)
              nxt.handle = cpra_pkg::HND_W'(
                live_heads[$urandom_range(live_heads.size() - 1)]);
          end
          cur_item <= nxt;
          start <= 1'b1;
          in_cmd <= nxt.cmd;
          in_request_bytes <= nxt.bytes;
          in_run_handle <= nxt.handle;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  run_res_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      seen_cnt++;
      if (awaited_q.size() == 0) begin
        $error("result with nothing awaited: status %0d", out_status);
        fail_cnt++;
      end else begin
        want = awaited_q.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_cnt++;
        end
        if (out_first_page !== want.first_page) begin
          $error("first_page: expected %0d, got %0d", want.first_page, out_first_page);
          fail_cnt++;
        end
        if (out_page_count !== want.page_count) begin
          $error("page_count: expected %0d, got %0d", want.page_count, out_page_count);
          fail_cnt++;
        end
        if (want.status == cpra_pkg::ST_OK && want.page_count != 0) begin
          alloc_ok_cnt++;
        end
      end
    end
  end

  task automatic map_write(input bit hi, input logic [63:0] v);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= hi ? 4'h8 : 4'h0;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (hi) page_map[127:64] = v;
    else page_map[63:0] = v;
  endtask

  task automatic drain_all();
    do @(posedge clk); while (pending_q.size() != 0 || start || awaited_q.size() != 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic add(input logic [cpra_pkg::CMD_W-1:0] c,
                     input logic [cpra_pkg::REQ_W-1:0] b,
                     input logic [cpra_pkg::HND_W-1:0] h, input bit lv);
    pending_q.push_back('{c, b, h, lv});
  endtask

  function automatic logic [cpra_pkg::REQ_W-1:0] pages_bytes(int n);
    return cpra_pkg::REQ_W'((n - 1) * 32'h200000 + $urandom_range(1, 32'h200000));
  endfunction

  task automatic random_items(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 3)
        add(cpra_pkg::CMD_FORM, cpra_pkg::REQ_W'($urandom), cpra_pkg::HND_W'($urandom),
            1'b0);
      else if (k < 6)
        add(CMD_UNUSED, cpra_pkg::REQ_W'($urandom), cpra_pkg::HND_W'($urandom), 1'b0);
      else if (k < 9)
        add(cpra_pkg::CMD_FREE, '0, cpra_pkg::HND_W'($urandom), 1'b0);
      else if (k < 11)
        add(cpra_pkg::CMD_ALLOC, '0, cpra_pkg::HND_W'($urandom), 1'b0);
      else if (k < 14)
        add(cpra_pkg::CMD_ALLOC, cpra_pkg::REQ_W'($urandom_range(0, 268435456)), '0, 1'b0);
      else if (k < 60)
        add(cpra_pkg::CMD_ALLOC, pages_bytes($urandom_range(1, 8)), '0, 1'b0);
      else
        add(cpra_pkg::CMD_FREE, '0, cpra_pkg::HND_W'($urandom), 1'b1);
    end
  endtask

  logic [63:0] lo_v, hi_v;
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    map_write(1'b0, '0);
    map_write(1'b1, '0);
    // before forming, with an empty map
    add(cpra_pkg::CMD_ALLOC, 29'd1, '0, 1'b0);
    add(cpra_pkg::CMD_FREE, '0, 7'd0, 1'b0);
    add(CMD_UNUSED, '1, '1, 1'b0);
    add(cpra_pkg::CMD_FORM, '0, '0, 1'b0);
    add(cpra_pkg::CMD_ALLOC, '0, '0, 1'b0);
    add(cpra_pkg::CMD_ALLOC, 29'd268435456, '0, 1'b0);
    add(cpra_pkg::CMD_ALLOC, 29'd1, '0, 1'b0);
    add(cpra_pkg::CMD_FREE, '0, 7'd127, 1'b0);
    add(cpra_pkg::CMD_FREE, '0, 7'd0, 1'b1);
    add(cpra_pkg::CMD_FREE, '0, 7'd0, 1'b1);
    drain_all();
    map_write(1'b0, '1);
    map_write(1'b1, '1);
    add(cpra_pkg::CMD_FORM, '0, '0, 1'b0);
    add(cpra_pkg::CMD_ALLOC, 29'h1FFFFFFF, '0, 1'b0);
    add(cpra_pkg::CMD_ALLOC, 29'd268435456, '0, 1'b0);
    add(cpra_pkg::CMD_FREE, '0, 7'd0, 1'b1);
    add(cpra_pkg::CMD_ALLOC, 29'h200000, '0, 1'b0);
    add(cpra_pkg::CMD_ALLOC, 29'h200001, '0, 1'b0);
    add(cpra_pkg::CMD_ALLOC, pages_bytes(5), '0, 1'b0);
    add(cpra_pkg::CMD_FREE, '0, 7'd127, 1'b0);
    add(cpra_pkg::CMD_FREE, '0, 7'd0, 1'b1);
    add(cpra_pkg::CMD_FREE, '0, 7'd0, 1'b1);
    add(cpra_pkg::CMD_FREE, '0, 7'd0, 1'b1);
    add(cpra_pkg::CMD_FORM, '0, '0, 1'b0);
    drain_all();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin lo_v = $urandom | ($urandom << 32) | {$urandom, $urandom};
                 hi_v = {$urandom, $urandom} | {$urandom, $urandom}; gap_pct = 0; end
        1: begin lo_v = {$urandom, $urandom}; hi_v = {$urandom, $urandom}; gap_pct = 88; end
        2: begin lo_v = '1; hi_v = '0; gap_pct = 7; end
        3: begin lo_v = {$urandom, $urandom} | {$urandom, $urandom}; hi_v = '1; gap_pct = 0; end
        4: begin lo_v = '0; hi_v = {$urandom, $urandom} | {$urandom, $urandom}; gap_pct = 88; end
        default: begin lo_v = {$urandom, $urandom} | {$urandom, $urandom};
                       hi_v = {$urandom, $urandom} | {$urandom, $urandom}; gap_pct = 7; end
      endcase
      map_write(1'b0, lo_v);
      map_write(1'b1, hi_v);
      add(cpra_pkg::CMD_FORM, '0, '0, 1'b0);
      random_items(74);
      drain_all();
    end
    $display("checked %0d results, %0d of them runs handed out or merged back,",
             seen_cnt, alloc_ok_cnt);
    $display("over eight page maps with the sender idling 0, 7 and 88 percent");
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### sim.f
sv/cpra_pkg.sv
sv/cpra_regs.sv
sv/cpra_ctrl.sv
sv/cpra_dp.sv
sv/contiguous_page_run_allocator.sv
sv/cpra_checker.sv
verif/tb_top.sv
